// ----- hw/rtl/sti_pkg.sv -----
`timescale 1ns / 1ps

package sti_pkg;

   localparam int unsigned SERIES_DEPTH_DEFAULT = 1024;

   localparam int unsigned OP_W           = 2;
   localparam int unsigned TIME_W         = 64;
   localparam int unsigned VALUE_W        = 32;
   localparam int unsigned STATUS_W       = 2;
   localparam int unsigned STORED_COUNT_W = 11;

   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
   localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_FIRST,
      ST_LAST,
      ST_SEARCH,
      ST_PROBE,
      ST_LO,
      ST_HI,
      ST_MUL0,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_APPLY,
      ST_DONE
   } state_type;

endpackage

// ----- hw/rtl/series_time_interpolator.sv -----
`timescale 1ns / 1ps

// Piecewise-linear lookup over a stored time series of up to SERIES_DEPTH samples
// (signed 64-bit ns timestamps, signed Q16.16 values). One item is worked on at a
// time; the next is taken once the previous result sits in the output register,
// even while that result is still stalled. Clear, append and unused codes go straight
// to the result; so does a query on an empty series. A query that lands at or outside
// the ends is settled by the first-sample and last-sample compares. An interior
// query runs a binary search over the stored samples, in which each probe takes
// an address state and a compare state on the one read port of the sample
// memories, and the interpolation fraction comes from a 64x32 product in two
// partial products followed by a restoring divider that yields one quotient bit
// per cycle. No clearing pass runs after reset.
module series_time_interpolator #(
   parameter int unsigned SERIES_DEPTH = sti_pkg::SERIES_DEPTH_DEFAULT
) (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       req_valid,
   output logic                                       req_stall,
   input  logic        [sti_pkg::OP_W-1:0]            req_operation,
   input  logic signed [sti_pkg::TIME_W-1:0]          req_sample_time,
   input  logic signed [sti_pkg::VALUE_W-1:0]         req_sample_value,
   output logic                                       rsp_valid,
   input  logic                                       rsp_stall,
   output logic signed [sti_pkg::VALUE_W-1:0]         rsp_interpolated_value,
   output logic        [sti_pkg::STATUS_W-1:0]        rsp_status,
   output logic        [sti_pkg::STORED_COUNT_W-1:0]  rsp_stored_count
);

   import sti_pkg::*;

   localparam int unsigned ADDR_W = (SERIES_DEPTH > 1) ? $clog2(SERIES_DEPTH) : 1;
   localparam int unsigned CNT_W  = $clog2(SERIES_DEPTH + 1);
   localparam int unsigned HALF_W = TIME_W / 2;
   localparam int unsigned STEP_W = $clog2(VALUE_W);

   logic signed [TIME_W-1:0]  time_mem [SERIES_DEPTH];
   logic signed [VALUE_W-1:0] value_mem [SERIES_DEPTH];

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic signed [TIME_W-1:0]  qtime_ff, qtime_in;
   logic [CNT_W-1:0]          first_ff, first_in;
   logic [CNT_W-1:0]          len_ff, len_in;
   logic [ADDR_W-1:0]         hi_ff, hi_in;
   logic signed [TIME_W-1:0]  tlo_ff, tlo_in;
   logic signed [VALUE_W-1:0] vlo_ff, vlo_in;
   logic [TIME_W-1:0]         span_ff, span_in;
   logic [TIME_W-1:0]         dt_ff, dt_in;
   logic [VALUE_W-1:0]        mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [TIME_W-1:0]         prod_lo_ff, prod_lo_in;
   logic [TIME_W-1:0]         prod_hi_ff, prod_hi_in;
   logic [TIME_W-1:0]         rem_ff, rem_in;
   logic [VALUE_W-1:0]        quo_ff, quo_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic signed [VALUE_W-1:0] res_value_ff, res_value_in;
   logic [STATUS_W-1:0]       res_status_ff, res_status_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, rsp_value_in;
   logic [STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [STORED_COUNT_W-1:0] rsp_count_ff, rsp_count_in;

   logic signed [TIME_W-1:0]  rd_time_ff;
   logic signed [VALUE_W-1:0] rd_value_ff;
   logic [ADDR_W-1:0]         rd_addr;
   logic                      mem_we;

   logic                      accept;
   logic                      out_free;
   logic [CNT_W-1:0]          last_idx;
   logic [CNT_W-1:0]          half;
   logic [CNT_W-1:0]          probe_idx;
   logic [CNT_W-1:0]          hi_floor;
   logic [CNT_W-1:0]          hi_sel;
   logic [CNT_W-1:0]          lo_sel;
   logic signed [VALUE_W:0]   dv;
   logic [VALUE_W:0]          dv_abs;
   logic [TIME_W:0]           shifted;
   logic                      div_ge;
   logic [TIME_W:0]           div_diff;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   assign last_idx  = count_ff - CNT_W'(1);
   assign half      = len_ff >> 1;
   assign probe_idx = first_ff + half;
   assign hi_floor  = (first_ff == '0) ? CNT_W'(1) : first_ff;
   assign hi_sel    = (hi_floor > last_idx) ? last_idx : hi_floor;
   assign lo_sel    = hi_sel - CNT_W'(1);

   assign dv     = {rd_value_ff[VALUE_W-1], rd_value_ff} - {vlo_ff[VALUE_W-1], vlo_ff};
   assign dv_abs = dv[VALUE_W] ? -dv : dv;

   assign shifted  = {rem_ff, quo_ff[VALUE_W-1]};
   assign div_ge   = (shifted >= {1'b0, span_ff});
   assign div_diff = shifted - {1'b0, span_ff};

   assign mem_we = accept && (req_operation == OP_APPEND)
                   && (count_ff < CNT_W'(SERIES_DEPTH));

   always_ff @(posedge clock) begin
      if (mem_we) begin
         time_mem[count_ff[ADDR_W-1:0]]  <= req_sample_time;
         value_mem[count_ff[ADDR_W-1:0]] <= req_sample_value;
      end
      rd_time_ff  <= time_mem[rd_addr];
      rd_value_ff <= value_mem[rd_addr];
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      qtime_in      = qtime_ff;
      first_in      = first_ff;
      len_in        = len_ff;
      hi_in         = hi_ff;
      tlo_in        = tlo_ff;
      vlo_in        = vlo_ff;
      span_in       = span_ff;
      dt_in         = dt_ff;
      mag_in        = mag_ff;
      neg_in        = neg_ff;
      prod_lo_in    = prod_lo_ff;
      prod_hi_in    = prod_hi_ff;
      rem_in        = rem_ff;
      quo_in        = quo_ff;
      step_in       = step_ff;
      res_value_in  = res_value_ff;
      res_status_in = res_status_ff;
      rd_addr       = '0;

      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_value_in  = rsp_value_ff;
      rsp_status_in = rsp_status_ff;
      rsp_count_in  = rsp_count_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_value_in  = '0;
               res_status_in = STATUS_OK;
               qtime_in      = req_sample_time;
               state_in      = ST_DONE;
               case (req_operation)
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_APPEND: begin
                     if (count_ff < CNT_W'(SERIES_DEPTH)) begin
                        count_in = count_ff + CNT_W'(1);
                     end else begin
                        res_status_in = STATUS_FULL;
                     end
                  end
                  OP_QUERY: begin
                     if (count_ff == '0) begin
                        res_status_in = STATUS_EMPTY;
                     end else begin
                        state_in = ST_FIRST;
                     end
                  end
                  default: begin
                     state_in = ST_DONE;
                  end
               endcase
            end
         end
         ST_FIRST: begin
            if (!(rd_time_ff < qtime_ff)) begin
               res_value_in = rd_value_ff;
               state_in     = ST_DONE;
            end else begin
               rd_addr  = last_idx[ADDR_W-1:0];
               state_in = ST_LAST;
            end
         end
         ST_LAST: begin
            if (!(qtime_ff < rd_time_ff)) begin
               res_value_in = rd_value_ff;
               state_in     = ST_DONE;
            end else begin
               first_in = '0;
               len_in   = count_ff;
               state_in = ST_SEARCH;
            end
         end
         ST_SEARCH: begin
            if (len_ff == '0) begin
               rd_addr  = lo_sel[ADDR_W-1:0];
               hi_in    = hi_sel[ADDR_W-1:0];
               state_in = ST_LO;
            end else begin
               rd_addr  = probe_idx[ADDR_W-1:0];
               state_in = ST_PROBE;
            end
         end
         ST_PROBE: begin
            if (rd_time_ff < qtime_ff) begin
               first_in = probe_idx + CNT_W'(1);
               len_in   = len_ff - half - CNT_W'(1);
            end else begin
               len_in = half;
            end
            state_in = ST_SEARCH;
         end
         ST_LO: begin
            tlo_in   = rd_time_ff;
            vlo_in   = rd_value_ff;
            rd_addr  = hi_ff;
            state_in = ST_HI;
         end
         ST_HI: begin
            span_in = rd_time_ff - tlo_ff;
            dt_in   = qtime_ff - tlo_ff;
            neg_in  = dv[VALUE_W];
            mag_in  = dv_abs[VALUE_W-1:0];
            if (!(tlo_ff < rd_time_ff) || !(tlo_ff < qtime_ff)) begin
               res_value_in = vlo_ff;
               state_in     = ST_DONE;
            end else if (!(qtime_ff < rd_time_ff)) begin
               res_value_in = rd_value_ff;
               state_in     = ST_DONE;
            end else begin
               state_in = ST_MUL0;
            end
         end
         ST_MUL0: begin
            prod_lo_in = dt_ff[HALF_W-1:0] * mag_ff;
            state_in   = ST_MUL1;
         end
         ST_MUL1: begin
            prod_hi_in = dt_ff[TIME_W-1:HALF_W] * mag_ff;
            state_in   = ST_MUL2;
         end
         ST_MUL2: begin
            rem_in   = prod_hi_ff + {{HALF_W{1'b0}}, prod_lo_ff[TIME_W-1:HALF_W]};
            quo_in   = prod_lo_ff[HALF_W-1:0];
            step_in  = '0;
            state_in = ST_DIV;
         end
         ST_DIV: begin
            rem_in  = div_ge ? div_diff[TIME_W-1:0] : shifted[TIME_W-1:0];
            quo_in  = {quo_ff[VALUE_W-2:0], div_ge};
            step_in = step_ff + STEP_W'(1);
            if (step_ff == STEP_W'(VALUE_W - 1)) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            res_value_in = neg_ff ? (vlo_ff - $signed(quo_ff)) : (vlo_ff + $signed(quo_ff));
            state_in     = ST_DONE;
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_value_in  = res_value_ff;
               rsp_status_in = res_status_ff;
               rsp_count_in  = STORED_COUNT_W'(count_ff);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      qtime_ff      <= qtime_in;
      first_ff      <= first_in;
      len_ff        <= len_in;
      hi_ff         <= hi_in;
      tlo_ff        <= tlo_in;
      vlo_ff        <= vlo_in;
      span_ff       <= span_in;
      dt_ff         <= dt_in;
      mag_ff        <= mag_in;
      neg_ff        <= neg_in;
      prod_lo_ff    <= prod_lo_in;
      prod_hi_ff    <= prod_hi_in;
      rem_ff        <= rem_in;
      quo_ff        <= quo_in;
      step_ff       <= step_in;
      res_value_ff  <= res_value_in;
      res_status_ff <= res_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_status_ff <= rsp_status_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_interpolated_value = rsp_value_ff;
   assign rsp_status             = rsp_status_ff;
   assign rsp_stored_count       = rsp_count_ff;

endmodule

// ----- hw/rtl/sti_checker.sv -----
`timescale 1ns / 1ps

module sti_checker #(
   parameter int unsigned SERIES_DEPTH = sti_pkg::SERIES_DEPTH_DEFAULT
) (
   input logic                                      clock,
   input logic                                      reset,
   input logic                                      rsp_valid,
   input logic                                      rsp_stall,
   input logic signed [sti_pkg::VALUE_W-1:0]        rsp_interpolated_value,
   input logic        [sti_pkg::STATUS_W-1:0]       rsp_status,
   input logic        [sti_pkg::STORED_COUNT_W-1:0] rsp_stored_count
);

   import sti_pkg::*;

   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_hold_stalled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_interpolated_value)
                                 && $stable(rsp_status) && $stable(rsp_stored_count))
      else $error("stalled result item changed");

   a_empty_query: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_EMPTY)
         |-> (rsp_stored_count == '0) && (rsp_interpolated_value == '0))
      else $error("empty status with samples held or nonzero value");

   a_full_drop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STATUS_FULL)
         |-> (rsp_stored_count == STORED_COUNT_W'(SERIES_DEPTH))
             && (rsp_interpolated_value == '0))
      else $error("full status while store not full");

endmodule

bind series_time_interpolator sti_checker #(
   .SERIES_DEPTH(SERIES_DEPTH)
) u_sti_checker (
   .clock                  (clock),
   .reset                  (reset),
   .rsp_valid              (rsp_valid),
   .rsp_stall              (rsp_stall),
   .rsp_interpolated_value (rsp_interpolated_value),
   .rsp_status             (rsp_status),
   .rsp_stored_count       (rsp_stored_count)
);

// ----- tb/series_time_interpolator_tb.sv -----
`timescale 1ns / 1ps

module series_time_interpolator_tb;
   import sti_pkg::*;

   localparam int unsigned SERIES_DEPTH = SERIES_DEPTH_DEFAULT;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic signed [TIME_W-1:0] TIME_MIN = 64'sh8000_0000_0000_0000;
   localparam logic signed [TIME_W-1:0] TIME_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
   localparam int RANDOM_ITEMS = 450;
   localparam int DRAIN_CYCLES = 80;

   typedef struct packed {
      logic signed [VALUE_W-1:0]   value;
      logic [STATUS_W-1:0]         status;
      logic [STORED_COUNT_W-1:0]   count;
   } lookup_result_type;

   class series_tracker_type;
      logic signed [TIME_W-1:0]  sample_times [SERIES_DEPTH];
      logic signed [VALUE_W-1:0] sample_values [SERIES_DEPTH];
      int unsigned               sample_total = 0;
      lookup_result_type         pending_lookups [$];
      int                        failures = 0;
      int                        checked = 0;
      int                        queries = 0;
      int                        drops = 0;

      function logic signed [VALUE_W-1:0] lookup_value(logic signed [TIME_W-1:0] t);
         int unsigned n, first, len, half, hi, lo;
         logic signed [TIME_W-1:0] t_lo, t_hi;
         logic signed [VALUE_W:0]  v_lo, v_hi, dv;
         logic [TIME_W-1:0]        span, dt;
         logic [VALUE_W-1:0]       mag, q;
         logic [127:0]             prod, quo;
         n = sample_total;
         if (t <= sample_times[0]) return sample_values[0];
         if (t >= sample_times[n-1]) return sample_values[n-1];
         first = 0;
         len = n;
         while (len > 0) begin
            half = len / 2;
            if (sample_times[first+half] < t) begin
               first += half + 1;
               len -= half + 1;
            end else begin
               len = half;
            end
         end
         hi = first;
         if (hi < 1) hi = 1;
         if (hi > n - 1) hi = n - 1;
         lo = hi - 1;
         t_lo = sample_times[lo];
         t_hi = sample_times[hi];
         if (t_lo >= t_hi || t <= t_lo) return sample_values[lo];
         if (t >= t_hi) return sample_values[hi];
         v_lo = sample_values[lo];
         v_hi = sample_values[hi];
         dv = v_hi - v_lo;
         if (dv < 0) mag = VALUE_W'(-dv);
         else mag = VALUE_W'(dv);
         span = t_hi - t_lo;
         dt = t - t_lo;
         prod = 128'(dt) * 128'(mag);
         quo = prod / 128'(span);
         q = quo[VALUE_W-1:0];
         if (dv < 0) return sample_values[lo] - q;
         return sample_values[lo] + q;
      endfunction

      function void note_item(logic [OP_W-1:0] op, logic signed [TIME_W-1:0] t,
                              logic signed [VALUE_W-1:0] v);
         lookup_result_type r;
         r.value = '0;
         r.status = STATUS_OK;
         case (op)
            OP_CLEAR: sample_total = 0;
            OP_APPEND: begin
               if (sample_total < SERIES_DEPTH) begin
                  sample_times[sample_total] = t;
                  sample_values[sample_total] = v;
                  sample_total++;
               end else begin
                  r.status = STATUS_FULL;
                  drops++;
               end
            end
            OP_QUERY: begin
               queries++;
               if (sample_total == 0) r.status = STATUS_EMPTY;
               else r.value = lookup_value(t);
            end
            default: ;
         endcase
         r.count = STORED_COUNT_W'(sample_total);
         pending_lookups = {pending_lookups, r};
      endfunction

      function void check_result(logic signed [VALUE_W-1:0] value,
                                 logic [STATUS_W-1:0] status,
                                 logic [STORED_COUNT_W-1:0] count);
         lookup_result_type r;
         if (pending_lookups.size() == 0) begin
            $error("result item arrived with nothing pending");
            failures++;
            return;
         end
         r = pending_lookups.pop_front();
         checked++;
         if (value !== r.value) begin
            $error("interpolated_value: expected %0d, actual %0d", r.value, value);
            failures++;
         end
         if (status !== r.status) begin
            $error("status: expected %0d, actual %0d", r.status, status);
            failures++;
         end
         if (count !== r.count) begin
            $error("stored_count: expected %0d, actual %0d", r.count, count);
            failures++;
         end
      endfunction
   endclass

   logic                         clock = 1'b0;
   logic                         reset;
   logic                         req_valid;
   logic                         req_stall;
   logic [OP_W-1:0]              req_operation;
   logic signed [TIME_W-1:0]     req_sample_time;
   logic signed [VALUE_W-1:0]    req_sample_value;
   logic                         rsp_valid;
   logic                         rsp_stall;
   logic signed [VALUE_W-1:0]    rsp_interpolated_value;
   logic [STATUS_W-1:0]          rsp_status;
   logic [STORED_COUNT_W-1:0]    rsp_stored_count;

   series_tracker_type           tracker;
   bit                           quiet = 1'b0;
   int                           items_sent = 0;
   logic signed [TIME_W-1:0]     built_times [$];

   series_time_interpolator #(
      .SERIES_DEPTH(SERIES_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_operation(req_operation),
      .req_sample_time(req_sample_time),
      .req_sample_value(req_sample_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_interpolated_value(rsp_interpolated_value),
      .rsp_status(rsp_status),
      .rsp_stored_count(rsp_stored_count)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         tracker.check_result(rsp_interpolated_value, rsp_status, rsp_stored_count);
   end

   initial begin
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!quiet && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 7)) @(posedge clock);
            rsp_stall <= 1'b0;
         end else begin
            repeat ($urandom_range(1, 12)) @(posedge clock);
         end
      end
   end

   function automatic logic signed [TIME_W-1:0] sat_add(logic signed [TIME_W-1:0] a,
                                                        logic signed [TIME_W-1:0] b);
      logic signed [TIME_W:0] s;
      s = a + b;
      if (s > TIME_MAX) return TIME_MAX;
      if (s < TIME_MIN) return TIME_MIN;
      return s[TIME_W-1:0];
   endfunction

   function automatic logic signed [TIME_W-1:0] rand_time();
      return {$urandom, $urandom};
   endfunction

   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return VALUE_MIN;
         1: return VALUE_MAX;
         2: return $urandom_range(0, 2000) - 1000;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic signed [TIME_W-1:0] pick_query_time();
      int unsigned i;
      logic [TIME_W-1:0] gap;
      logic [127:0] frac;
      logic signed [TIME_W-1:0] off;
      if (built_times.size() == 0) return rand_time();
      i = $urandom_range(0, built_times.size() - 1);
      off = $urandom_range(1, 1000);
      case ($urandom_range(0, 6))
         0: return built_times[i];
         1, 2: begin
            if (i + 1 >= built_times.size()) return built_times[i];
            gap = built_times[i+1] - built_times[i];
            frac = (128'(gap) * 128'($urandom)) >> 32;
            return built_times[i] + frac[TIME_W-1:0];
         end
         3: return sat_add(built_times[i], 64'sd10 - 64'($urandom_range(0, 20)));
         4: return sat_add(built_times[0], -off);
         5: return sat_add(built_times[built_times.size()-1], off);
         default: return rand_time();
      endcase
   endfunction

   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [TIME_W-1:0] t,
                            input logic signed [VALUE_W-1:0] v);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 7)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_operation    <= op;
      req_sample_time  <= t;
      req_sample_value <= v;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      tracker.note_item(op, t, v);
      if (op != OP_UNUSED) items_sent++;
   endtask

   task automatic load_series(input int k);
      logic signed [TIME_W-1:0] t, step;
      int mode;
      mode = $urandom_range(0, 3);
      send_item(OP_CLEAR, rand_time(), $urandom);
      built_times.delete();
      case (mode)
         0: t = 64'($urandom_range(0, 20000)) - 64'sd10000;
         1: t = rand_time() >>> 2;
         2: t = TIME_MIN;
         default: t = rand_time();
      endcase
      for (int i = 0; i < k; i++) begin
         if (i > 0) begin
            case (mode)
               0: step = $urandom_range(0, 100);
               1: step = {$urandom, $urandom} >> 8;
               2: step = {$urandom, $urandom} >> 4;
               default: step = {$urandom, $urandom} >> $urandom_range(1, 63);
            endcase
            t = sat_add(t, step);
         end
         send_item(OP_APPEND, t, pick_value());
         built_times = {built_times, t};
      end
   endtask

   task automatic probe_series(input int m);
      for (int i = 0; i < m; i++)
         send_item(OP_QUERY, pick_query_time(), $urandom);
   endtask

   task automatic send_noise(input int m);
      for (int i = 0; i < m; i++)
         send_item(logic'($urandom_range(0, 1)) ? OP_UNUSED : OP_CLEAR, rand_time(), $urandom);
   endtask

   task automatic send_broken(input int m);
      logic signed [TIME_W-1:0] t;
      for (int i = 0; i < m; i++) begin
         if (built_times.size() != 0 && $urandom_range(0, 1) == 0)
            t = sat_add(built_times[built_times.size()-1], -64'($urandom_range(0, 5000)));
         else
            t = rand_time();
         send_item(OP_APPEND, t, pick_value());
         built_times = {built_times, t};
      end
      probe_series($urandom_range(2, 5));
   endtask

   initial begin
      int random_stop;
      tracker = new();
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_operation    <= OP_CLEAR;
      req_sample_time  <= '0;
      req_sample_value <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      send_item(OP_QUERY, 64'sd0, 32'sd0);
      send_item(OP_UNUSED, TIME_MAX, VALUE_MAX);
      send_item(OP_CLEAR, TIME_MIN, VALUE_MIN);
      send_item(OP_APPEND, TIME_MIN, VALUE_MIN);
      send_item(OP_QUERY, TIME_MAX, 32'sd0);
      send_item(OP_QUERY, TIME_MIN, 32'sd0);
      send_item(OP_APPEND, TIME_MAX, VALUE_MAX);
      send_item(OP_QUERY, 64'sd0, 32'sd0);
      send_item(OP_QUERY, -64'sd1, 32'sd0);
      send_item(OP_QUERY, TIME_MIN + 64'sd1, 32'sd0);
      send_item(OP_QUERY, TIME_MAX - 64'sd1, 32'sd0);
      send_item(OP_APPEND, 64'sd0, 32'sd5);
      send_item(OP_QUERY, 64'sd1, 32'sd0);
      send_item(OP_QUERY, -64'sd5, 32'sd0);
      send_item(OP_CLEAR, 64'sd0, 32'sd0);
      send_item(OP_QUERY, 64'sd7, 32'sd0);
      send_item(OP_APPEND, 64'sd100, 32'sd1000);
      send_item(OP_APPEND, 64'sd100, -32'sd7);
      send_item(OP_APPEND, 64'sd200, -32'sd2000);
      send_item(OP_QUERY, 64'sd100, 32'sd0);
      send_item(OP_QUERY, 64'sd150, 32'sd0);
      send_item(OP_QUERY, 64'sd199, 32'sd0);
      send_item(OP_UNUSED, 64'sd150, 32'sd0);
      send_item(OP_APPEND, 64'sd50, 32'sd42);
      send_item(OP_QUERY, 64'sd120, 32'sd0);
      send_item(OP_QUERY, 64'sd60, 32'sd0);

      random_stop = items_sent + RANDOM_ITEMS;
      while (items_sent < random_stop) begin
         case ($urandom_range(0, 9))
            0: send_noise($urandom_range(1, 6));
            1: send_broken($urandom_range(1, 6));
            default: begin
               load_series(($urandom_range(0, 7) == 0) ? $urandom_range(13, 60)
                                                      : $urandom_range(1, 12));
               probe_series($urandom_range(3, 10));
            end
         endcase
      end

      load_series(SERIES_DEPTH);
      for (int i = 0; i < 3; i++)
         send_item(OP_APPEND, rand_time(), pick_value());
      probe_series(10);
      send_item(OP_UNUSED, rand_time(), $urandom);

      quiet = 1'b1;
      load_series(8);
      probe_series(10);
      send_item(OP_CLEAR, rand_time(), $urandom);
      send_item(OP_QUERY, rand_time(), $urandom);
      req_valid <= 1'b0;

      while (tracker.pending_lookups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run sent %0d items and checked %0d results: %0d queries, %0d full drops.",
               items_sent, tracker.checked, tracker.queries, tracker.drops);
      if (tracker.failures == 0 && tracker.pending_lookups.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hw/rtl/sti_pkg.sv
hw/rtl/series_time_interpolator.sv
hw/rtl/sti_checker.sv
tb/series_time_interpolator_tb.sv
